@@ hw/rtl/spq_pkg.sv @@
package spq_pkg;

   localparam int unsigned DEF_CAPACITY   = 8;
   localparam int unsigned DEF_VALUE_BITS = 16;

   // Port widths of the request and response beats
   localparam int unsigned JOB_BITS = 16;
   localparam int unsigned OCC_BITS = 4;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic ins;   // shift right from the insert point, write the new value
      logic rem;   // shift every cell one place toward the head
   } spq_cmd_type;

endpackage

@@ hw/rtl/sorted_priority_queue.sv @@
// Bounded priority queue of up to CAPACITY values kept in ascending order in a
// chain of cells, the smallest at the head. Every request beat is one operation:
// an insert (kind 0) places job_value behind all stored values that are less or
// equal, so equal values leave in arrival order; a remove (kind 1) returns the
// head value and shifts the rest one cell toward the head. Each request gives
// exactly one response beat with status (done, full, empty), the removed value
// (zero unless a remove succeeded) and the occupancy after the operation.
// Every cell compares its value with the incoming one in parallel and moves
// data only to its neighbor, so one request is accepted in every cycle unless
// req_stall holds it, and the response beat is registered. req_stall is high
// only while a response waits and rsp_stall holds it. Values are stored on
// VALUE_BITS bits; job_value is truncated or zero-extended to that width, and
// the removed value to 16 bits on the port.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int unsigned CAPACITY   = DEF_CAPACITY,
   parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [JOB_BITS-1:0] req_job_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [JOB_BITS-1:0] rsp_removed_value,
   output logic [OCC_BITS-1:0] rsp_occupancy
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   // Entry count and response register
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic [1:0]          rsp_status_in;
   logic [JOB_BITS-1:0] rsp_removed_ff;
   logic [JOB_BITS-1:0] rsp_removed_in;
   logic [OCC_BITS-1:0] rsp_occupancy_ff;
   logic [OCC_BITS-1:0] rsp_occupancy_in;

   logic                  accept;
   logic                  is_insert;
   logic                  is_remove;
   logic                  full;
   logic                  empty;
   spq_cmd_type           cmd;
   logic [VALUE_BITS-1:0] new_value;

   logic [VALUE_BITS+JOB_BITS-1:0] job_wide;
   logic [VALUE_BITS+JOB_BITS-1:0] head_wide;
   logic [CW+OCC_BITS-1:0]         count_wide;

   // Chain taps: take flag and value of every cell
   logic [CAPACITY-1:0]   take_w;
   logic [VALUE_BITS-1:0] value_w [CAPACITY];

   // Hold the request while a finished response is stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_insert = (req_kind == KIND_INSERT);
   assign is_remove = (req_kind == KIND_REMOVE);
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign job_wide  = {{VALUE_BITS{1'b0}}, req_job_value};
   assign new_value = job_wide[VALUE_BITS-1:0];

   // Drop refused operations before they reach the chain
   assign cmd.ins = accept && is_insert && !full;
   assign cmd.rem = accept && is_remove && !empty;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                  left_take;
         logic [VALUE_BITS-1:0] left_value;
         logic [VALUE_BITS-1:0] right_value;

         if (gi == 0) begin : g_head
            assign left_take  = 1'b0;
            assign left_value = '0;
         end else begin : g_mid
            assign left_take  = take_w[gi-1];
            assign left_value = value_w[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign right_value = '0;
         end else begin : g_body
            assign right_value = value_w[gi+1];
         end

         spq_cell #(
            .CAPACITY   (CAPACITY),
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (gi)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .count       (count_ff),
            .new_value   (new_value),
            .left_take   (left_take),
            .left_value  (left_value),
            .right_value (right_value),
            .take        (take_w[gi]),
            .value       (value_w[gi])
         );
      end
   endgenerate

   assign head_wide = {{JOB_BITS{1'b0}}, value_w[0]};

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.rem) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_wide = {{OCC_BITS{1'b0}}, count_in};

   // Build the response beat of the accepted request
   always_comb begin
      rsp_status_in    = ST_DONE;
      rsp_removed_in   = '0;
      rsp_occupancy_in = count_wide[OCC_BITS-1:0];
      if (is_insert && full) begin
         rsp_status_in = ST_FULL;
      end else if (is_remove && empty) begin
         rsp_status_in = ST_EMPTY;
      end else if (is_remove) begin
         rsp_removed_in = head_wide[JOB_BITS-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_removed_ff   <= rsp_removed_in;
         rsp_occupancy_ff <= rsp_occupancy_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_occupancy     = rsp_occupancy_ff;

   // Count never runs past the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   // A successful insert grows the store by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not advance the count");

   // A refused operation leaves the store size alone
   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && ((is_insert && full) || (is_remove && empty))) |=> $stable(count_ff))
      else $error("refused operation changed the count");

   // Head pair stays in ascending order
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(2)) |-> (value_w[0] <= value_w[1]))
      else $error("head cells out of order");

endmodule

@@ hw/rtl/spq_cell.sv @@
module spq_cell
   import spq_pkg::*;
#(
   parameter int unsigned CAPACITY   = DEF_CAPACITY,
   parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
   parameter int unsigned INDEX      = 0,
   localparam int unsigned CW        = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  spq_cmd_type           cmd,
   input  logic [CW-1:0]         count,
   input  logic [VALUE_BITS-1:0] new_value,
   input  logic                  left_take,
   input  logic [VALUE_BITS-1:0] left_value,
   input  logic [VALUE_BITS-1:0] right_value,
   output logic                  take,
   output logic [VALUE_BITS-1:0] value
);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic                  occupied;

   assign occupied = count > CW'(INDEX);

   // New value belongs at or ahead of this slot
   assign take  = !occupied || (value_ff > new_value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.rem) begin
         value_in = right_value;
      end else if (cmd.ins && take) begin
         value_in = left_take ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ sim/sorted_priority_queue_tb.sv @@
module sorted_priority_queue_tb
   import spq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // One response beat as the block should deliver it
   typedef struct packed {
      status_type          status;
      logic [JOB_BITS-1:0] removed_value;
      logic [OCC_BITS-1:0] occupancy;
   } response_beat_type;

   // Scoreboard: keeps its own sorted copy of the store and the queue of
   // response beats still owed by the block.
   class spq_checker_type;
      logic [JOB_BITS-1:0] sorted_values[$];
      response_beat_type   owed_responses[$];
      int unsigned         mismatches;

      function void fail(string what);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s", $realtime, what);
      endfunction

      // Apply one accepted request beat to the shadow store and owe its response
      function void note_request(kind_type kind, logic [JOB_BITS-1:0] value);
         response_beat_type beat;
         int unsigned       pos;
         beat.status        = ST_DONE;
         beat.removed_value = '0;
         if (kind == KIND_INSERT) begin
            if (sorted_values.size() >= DEF_CAPACITY) begin
               beat.status = ST_FULL;
            end else begin
               // land behind every value that is less or equal
               pos = 0;
               while (pos < sorted_values.size() && sorted_values[pos] <= value)
                  pos++;
               sorted_values.insert(pos, value);
            end
         end else if (sorted_values.size() == 0) begin
            beat.status = ST_EMPTY;
         end else begin
            beat.removed_value = sorted_values.pop_front();
         end
         beat.occupancy = OCC_BITS'(sorted_values.size());
         owed_responses.push_back(beat);
      endfunction

      // Compare one accepted response beat with the oldest owed one
      function void check_response(logic [1:0] status, logic [JOB_BITS-1:0] removed,
                                   logic [OCC_BITS-1:0] occupancy);
         response_beat_type want;
         if (owed_responses.size() == 0) begin
            fail($sformatf("response beat with nothing owed: status %0d value %h occ %0d",
                           status, removed, occupancy));
         end else begin
            want = owed_responses.pop_front();
            if (status !== want.status || removed !== want.removed_value ||
                occupancy !== want.occupancy)
               fail($sformatf({"mismatch: expected status %0d value %h occ %0d, ",
                               "got status %0d value %h occ %0d"},
                              want.status, want.removed_value, want.occupancy,
                              status, removed, occupancy));
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_kind;
   logic [JOB_BITS-1:0] req_job_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_status;
   logic [JOB_BITS-1:0] rsp_removed_value;
   logic [OCC_BITS-1:0] rsp_occupancy;

   spq_checker_type board = new;
   bit              gaps_on;

   sorted_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_job_value     (req_job_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_occupancy     (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Drive one request beat, hold it until the block takes it, then idle for a
   // random gap when gaps are enabled. Valid stays high across back-to-back beats.
   task automatic send_request(kind_type kind, logic [JOB_BITS-1:0] value);
      int unsigned gap;
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_job_value <= value;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, value);
      gap = 0;
      if (gaps_on) begin
         case ($urandom_range(0, 49))
            0:                gap = $urandom_range(20, 60);
            1, 2, 3, 4:       gap = $urandom_range(4, 10);
            5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18:
                              gap = $urandom_range(1, 3);
            default:          gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: check every accepted beat, and throttle with rsp_stall in
   // runs of random length so stalls land on every phase of the traffic.
   initial begin
      int unsigned run_left;
      rsp_stall <= 1'b0;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_response(rsp_status, rsp_removed_value, rsp_occupancy);
         if (run_left == 0) begin
            case ($urandom_range(0, 49))
               0: begin
                  rsp_stall <= 1'b1;
                  run_left = $urandom_range(20, 80);
               end
               1, 2, 3, 4: begin
                  rsp_stall <= 1'b1;
                  run_left = $urandom_range(4, 12);
               end
               5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20: begin
                  rsp_stall <= 1'b1;
                  run_left = $urandom_range(1, 3);
               end
               default: begin
                  // open stretch with no backpressure at all
                  rsp_stall <= 1'b0;
                  run_left = $urandom_range(1, 40);
               end
            endcase
         end
         run_left--;
      end
   end

   // Stimulus and end of run
   initial begin
      int unsigned         items;
      int unsigned         burst_len;
      int unsigned         insert_pct;
      int unsigned         waited;
      kind_type            kind;
      logic [JOB_BITS-1:0] value;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_kind      <= KIND_INSERT;
      req_job_value <= '0;
      gaps_on        = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: remove from an empty store first
      send_request(KIND_REMOVE, 16'h0000);
      // Fill to capacity with extremes and runs of equal values
      send_request(KIND_INSERT, 16'hFFFF);
      send_request(KIND_INSERT, 16'h0000);
      send_request(KIND_INSERT, 16'h8000);
      send_request(KIND_INSERT, 16'h8000);
      send_request(KIND_INSERT, 16'h7FFF);
      send_request(KIND_INSERT, 16'h0001);
      send_request(KIND_INSERT, 16'h8000);
      send_request(KIND_INSERT, 16'hFFFF);
      // Store is full: both inserts must be refused, store untouched
      send_request(KIND_INSERT, 16'h1234);
      send_request(KIND_INSERT, 16'h0000);
      // Drain completely, then hit empty again
      repeat (8) send_request(KIND_REMOVE, 16'hFFFF);
      send_request(KIND_REMOVE, 16'h0000);
      // Alternating bit patterns in and out again
      send_request(KIND_INSERT, 16'h5555);
      send_request(KIND_INSERT, 16'hAAAA);
      send_request(KIND_REMOVE, 16'h0000);
      send_request(KIND_REMOVE, 16'h0000);

      // Random bursts: each burst leans toward filling, mixing or draining so
      // the store keeps swinging between full and empty.
      items = 0;
      while (items < 427) begin
         burst_len = $urandom_range(8, 40);
         if (burst_len > 427 - items)
            burst_len = 427 - items;
         case ($urandom_range(0, 3))
            0:       insert_pct = 85;
            1:       insert_pct = 20;
            2:       insert_pct = 50;
            default: insert_pct = 65;
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat (burst_len) begin
            kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            case ($urandom_range(0, 9))
               0:          value = 16'h0000;
               1:          value = 16'hFFFF;
               2, 3, 4:    value = JOB_BITS'($urandom_range(0, 7));   // force ties
               default:    value = JOB_BITS'($urandom);
            endcase
            send_request(kind, value);
            items++;
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed response, then keep watching for strays
      waited = 0;
      while (board.owed_responses.size() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (board.owed_responses.size() > 0)
         board.fail($sformatf("%0d response beats never arrived",
                              board.owed_responses.size()));

      if (board.mismatches == 0) begin
         $display("sorted_priority_queue test passed");
      end else begin
         $display("sorted_priority_queue test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("sorted_priority_queue test failed");
      $finish;
   end

endmodule
